### hw/rtl/gzhs_pkg.sv
// ----------------------------------------------------------------------------
// gzhs_pkg
// Shared types and codes for the gzip member header skipper.
// ----------------------------------------------------------------------------
package gzhs_pkg;

	// item opcodes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_HEADER   = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_PAYLOAD  = 3'd2,
		ST_SHORT    = 3'd3,
		ST_IDLE     = 3'd4
	} status_t;

	// flag byte bits
	localparam int unsigned FlgHcrc    = 1;
	localparam int unsigned FlgExtra   = 2;
	localparam int unsigned FlgName    = 3;
	localparam int unsigned FlgComment = 4;

	// pending section bits
	localparam int unsigned PendExtra   = 0;
	localparam int unsigned PendName    = 1;
	localparam int unsigned PendComment = 2;
	localparam int unsigned PendHcrc    = 3;

	// byte counts of the fixed part and of the header crc
	localparam logic [15:0] FixedLen = 16'd6;
	localparam logic [15:0] HcrcLen  = 16'd2;

	// input beat
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] in_byte;
	} item_t;

	// result beat
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] payload;
	} result_t;

endpackage

### hw/rtl/gzip_header_skipper_top.sv
// ----------------------------------------------------------------------------
// gzip_header_skipper_top
// Walks a gzip member header byte by byte and passes later bytes through.
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake           | beat
// ---------+-----+---------------------+-------------------------------
// item     | in  | item_valid/stall    | opcode, in_byte (item_t)
// result   | out | result_valid/stall  | status, payload (result_t)
//
// One beat per cycle unless the result side stalls: a beat lands in the input
// register, is decoded against the header state in the next cycle and the
// result enters the output register.
// Reset returns the parser to idle and empties both registers.
// A stalled result holds the output register; a beat in the input register then
// holds too and item_stall follows. An opcode of three yields no result beat.
module gzip_header_skipper_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  gzhs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output gzhs_pkg::result_t result
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_FIXED   = 4'd1,
		PH_XLEN_LO = 4'd2,
		PH_XLEN_HI = 4'd3,
		PH_XSKIP   = 4'd4,
		PH_NAME    = 4'd5,
		PH_COMMENT = 4'd6,
		PH_HCRC    = 4'd7,
		PH_PAYLOAD = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  pending;
		logic [15:0] remaining;
		logic [2:0]  status;
	} section_t;

	// advance to the next pending section, or finish the header
	function automatic section_t next_section(input logic [3:0] pending,
		input logic [15:0] remaining);
		section_t r;
		r.phase     = PH_PAYLOAD;
		r.pending   = pending;
		r.remaining = remaining;
		r.status    = gzhs_pkg::ST_HEADER;
		if (pending[gzhs_pkg::PendExtra]) begin
			r.pending[gzhs_pkg::PendExtra] = 1'b0;
			r.phase = PH_XLEN_LO;
		end else if (pending[gzhs_pkg::PendName]) begin
			r.pending[gzhs_pkg::PendName] = 1'b0;
			r.phase = PH_NAME;
		end else if (pending[gzhs_pkg::PendComment]) begin
			r.pending[gzhs_pkg::PendComment] = 1'b0;
			r.phase = PH_COMMENT;
		end else if (pending[gzhs_pkg::PendHcrc]) begin
			r.pending[gzhs_pkg::PendHcrc] = 1'b0;
			r.phase = PH_HCRC;
			r.remaining = gzhs_pkg::HcrcLen;
		end else begin
			r.status = gzhs_pkg::ST_COMPLETE;
		end
		return r;
	endfunction

	phase_t            phase_q, phase_d;
	logic [15:0]       remaining_q, remaining_d;
	logic [3:0]        pending_q, pending_d;
	logic [7:0]        xlen_lo_q, xlen_lo_d;

	logic              item_valid_s1;
	gzhs_pkg::item_t   item_s1;
	logic              result_valid_s2;
	gzhs_pkg::result_t result_s2;

	logic              advance;
	logic              emit;
	logic [2:0]        status_d;
	logic [7:0]        payload_d;
	logic [15:0]       dec;
	logic [15:0]       xlen;
	section_t          sec;

	// handshake control
	assign advance      = !result_valid_s2 || !result_stall;
	assign item_stall   = item_valid_s1 && !advance;
	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	assign dec  = remaining_q - 16'd1;
	assign xlen = {item_s1.in_byte, xlen_lo_q};

	// header walk for the beat in the input register
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		pending_d   = pending_q;
		xlen_lo_d   = xlen_lo_q;
		status_d    = gzhs_pkg::ST_HEADER;
		payload_d   = 8'd0;
		emit        = 1'b1;
		sec         = next_section(pending_q, remaining_q);
		unique case (item_s1.opcode)
			gzhs_pkg::OP_START: begin
				pending_d[gzhs_pkg::PendExtra]   = item_s1.in_byte[gzhs_pkg::FlgExtra];
				pending_d[gzhs_pkg::PendName]    = item_s1.in_byte[gzhs_pkg::FlgName];
				pending_d[gzhs_pkg::PendComment] = item_s1.in_byte[gzhs_pkg::FlgComment];
				pending_d[gzhs_pkg::PendHcrc]    = item_s1.in_byte[gzhs_pkg::FlgHcrc];
				phase_d     = PH_FIXED;
				remaining_d = gzhs_pkg::FixedLen;
				xlen_lo_d   = 8'd0;
			end
			gzhs_pkg::OP_END: begin
				status_d    = (phase_q >= PH_FIXED && phase_q <= PH_HCRC) ?
					gzhs_pkg::ST_SHORT : gzhs_pkg::ST_IDLE;
				phase_d     = PH_IDLE;
				remaining_d = 16'd0;
				pending_d   = 4'd0;
				xlen_lo_d   = 8'd0;
			end
			gzhs_pkg::OP_BYTE: begin
				unique case (phase_q) inside
					PH_FIXED, PH_XSKIP, PH_HCRC: begin
						remaining_d = dec;
						if (dec == 16'd0) begin
							sec         = next_section(pending_q, dec);
							phase_d     = sec.phase;
							pending_d   = sec.pending;
							remaining_d = sec.remaining;
							status_d    = sec.status;
						end
					end
					PH_XLEN_LO: begin
						xlen_lo_d = item_s1.in_byte;
						phase_d   = PH_XLEN_HI;
					end
					PH_XLEN_HI: begin
						remaining_d = xlen;
						if (xlen == 16'd0) begin
							sec         = next_section(pending_q, xlen);
							phase_d     = sec.phase;
							pending_d   = sec.pending;
							remaining_d = sec.remaining;
							status_d    = sec.status;
						end else begin
							phase_d = PH_XSKIP;
						end
					end
					PH_NAME, PH_COMMENT: begin
						if (item_s1.in_byte == 8'd0) begin
							phase_d     = sec.phase;
							pending_d   = sec.pending;
							remaining_d = sec.remaining;
							status_d    = sec.status;
						end
					end
					PH_PAYLOAD: begin
						status_d  = gzhs_pkg::ST_PAYLOAD;
						payload_d = item_s1.in_byte;
					end
					default: begin
						status_d = gzhs_pkg::ST_IDLE;
					end
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// parser state, updated when the registered beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= 16'd0;
			pending_q   <= 4'd0;
			xlen_lo_q   <= 8'd0;
		end else if (item_valid_s1 && advance) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			pending_q   <= pending_d;
			xlen_lo_q   <= xlen_lo_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= item_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1 && emit) begin
			result_s2.status  <= status_d;
			result_s2.payload <= payload_d;
		end
	end

endmodule

### test/gzhs_checker.sv
// ----------------------------------------------------------------------------
// gzhs_checker
// Watches both channels of the gzip header skipper, predicts every result beat
// from the accepted item beats and compares them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gzhs_checker
	import gzhs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      outstanding
);

	// header walk positions of the predictor
	typedef enum logic [3:0] {
		HP_IDLE    = 4'd0,
		HP_FIXED   = 4'd1,
		HP_XLEN_LO = 4'd2,
		HP_XLEN_HI = 4'd3,
		HP_XSKIP   = 4'd4,
		HP_NAME    = 4'd5,
		HP_COMMENT = 4'd6,
		HP_HCRC    = 4'd7,
		HP_PAYLOAD = 4'd8
	} hdr_phase_t;

	hdr_phase_t  hdr_phase;
	logic [15:0] bytes_left;
	logic [3:0]  sections_due;
	logic [7:0]  xlen_low;

	result_t     expected_results[$];

	// return the walk to idle
	function automatic void clear_walk();
		hdr_phase    = HP_IDLE;
		bytes_left   = '0;
		sections_due = '0;
		xlen_low     = '0;
	endfunction

	// step into the next optional section, or finish the header
	function automatic status_t open_next_section();
		if (sections_due[PendExtra]) begin
			sections_due[PendExtra] = 1'b0;
			hdr_phase = HP_XLEN_LO;
		end else if (sections_due[PendName]) begin
			sections_due[PendName] = 1'b0;
			hdr_phase = HP_NAME;
		end else if (sections_due[PendComment]) begin
			sections_due[PendComment] = 1'b0;
			hdr_phase = HP_COMMENT;
		end else if (sections_due[PendHcrc]) begin
			sections_due[PendHcrc] = 1'b0;
			hdr_phase = HP_HCRC;
			bytes_left = HcrcLen;
		end else begin
			hdr_phase = HP_PAYLOAD;
			return ST_COMPLETE;
		end
		return ST_HEADER;
	endfunction

	// advance the header walk by one item beat and work out its result
	task automatic walk_header(input item_t it, output bit produced, output result_t res);
		status_t    st;
		logic [7:0] pay;
		st       = ST_HEADER;
		pay      = '0;
		produced = 1'b1;
		case (opcode_t'(it.opcode))
			OP_NONE: begin
				produced = 1'b0;
			end
			OP_START: begin
				sections_due = '0;
				sections_due[PendExtra]   = it.in_byte[FlgExtra];
				sections_due[PendName]    = it.in_byte[FlgName];
				sections_due[PendComment] = it.in_byte[FlgComment];
				sections_due[PendHcrc]    = it.in_byte[FlgHcrc];
				hdr_phase  = HP_FIXED;
				bytes_left = FixedLen;
				xlen_low   = '0;
			end
			OP_END: begin
				st = (hdr_phase >= HP_FIXED && hdr_phase <= HP_HCRC) ? ST_SHORT : ST_IDLE;
				clear_walk();
			end
			default: begin
				case (hdr_phase)
					HP_FIXED, HP_XSKIP, HP_HCRC: begin
						bytes_left = bytes_left - 16'd1;
						if (bytes_left == '0)
							st = open_next_section();
					end
					HP_XLEN_LO: begin
						xlen_low  = it.in_byte;
						hdr_phase = HP_XLEN_HI;
					end
					HP_XLEN_HI: begin
						bytes_left = {it.in_byte, xlen_low};
						if (bytes_left == '0)
							st = open_next_section();
						else
							hdr_phase = HP_XSKIP;
					end
					HP_NAME, HP_COMMENT: begin
						if (it.in_byte == 8'h00)
							st = open_next_section();
					end
					HP_PAYLOAD: begin
						st  = ST_PAYLOAD;
						pay = it.in_byte;
					end
					default: begin
						st = ST_IDLE;
					end
				endcase
			end
		endcase
		res.status  = st;
		res.payload = pay;
	endtask

	// compare result beats with the oldest expectation, then predict new ones
	always @(posedge clk or negedge arst_n) begin
		bit      produced;
		result_t want;
		if (!arst_n) begin
			clear_walk();
			expected_results.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: status %0d payload 0x%02h",
						result.status, result.payload);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status || result.payload !== want.payload)
						fail_count <= fail_count + 1;
					if (result.status !== want.status)
						$error("status mismatch: expected %0d, actual %0d",
							want.status, result.status);
					if (result.payload !== want.payload)
						$error("payload mismatch: expected 0x%02h, actual 0x%02h",
							want.payload, result.payload);
				end
			end
			if (item_valid && !item_stall) begin
				walk_header(item, produced, want);
				if (produced)
					expected_results.push_back(want);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives gzip member headers, broken headers and noise into the header
// skipper with random idle bursts on both channels; the checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import gzhs_pkg::*;

	localparam int ItemCount  = 1650;
	localparam int CalmFrom   = 1400;
	localparam int StallLimit = 2000;
	localparam int DrainWait  = 8;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	int      fail_count;
	int      outstanding;
	int      beats_sent;
	int      stall_left;
	int      idle_cycles;
	bit      calm;
	item_t   member_beats[$];

	gzip_header_skipper_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	gzhs_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (calm) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= StallLimit) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// one item beat, with an optional idle burst in front
	task automatic send_beat(input opcode_t op, input logic [7:0] b);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= '{opcode: op, in_byte: b};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (op != OP_NONE)
			beats_sent++;
	endtask

	// random optional section body: nonzero bytes and a zero terminator
	task automatic add_zstring();
		int len;
		len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		repeat (len)
			member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'($urandom_range(1, 255))});
		member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'h00});
	endtask

	// one gzip member with random content, sometimes cut short or left open
	task automatic build_member();
		logic [7:0]  flags;
		logic [15:0] xlen;
		int          pick;
		int          cut;
		member_beats.delete();
		flags = 8'($urandom_range(0, 255));
		member_beats.push_back('{opcode: OP_START, in_byte: flags});
		repeat (int'(FixedLen))
			member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'($urandom)});
		if (flags[FlgExtra]) begin
			xlen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 300))
				: 16'($urandom_range(0, 6));
			member_beats.push_back('{opcode: OP_BYTE, in_byte: xlen[7:0]});
			member_beats.push_back('{opcode: OP_BYTE, in_byte: xlen[15:8]});
			repeat (int'(xlen))
				member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'($urandom)});
		end
		if (flags[FlgName])
			add_zstring();
		if (flags[FlgComment])
			add_zstring();
		if (flags[FlgHcrc])
			repeat (int'(HcrcLen))
				member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'($urandom)});
		repeat ($urandom_range(0, 8))
			member_beats.push_back('{opcode: OP_BYTE, in_byte: 8'($urandom)});

		// ending: truncated, left open for the next start, or closed
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			cut = $urandom_range(1, member_beats.size() - 1);
			while (member_beats.size() > cut)
				void'(member_beats.pop_back());
			member_beats.push_back('{opcode: OP_END, in_byte: 8'($urandom)});
		end else if (pick >= 5) begin
			member_beats.push_back('{opcode: OP_END, in_byte: 8'($urandom)});
		end

		// now and then a stray beat between members
		if ($urandom_range(0, 9) == 0)
			member_beats.push_back('{opcode: opcode_t'($urandom_range(0, 3)),
				in_byte: 8'($urandom)});
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		stall_left   = 0;
		idle_cycles  = 0;
		beats_sent   = 0;
		calm         = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: idle cases, all flags with empty sections, abandon, short header
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_END, 8'h00);
		send_beat(OP_NONE, 8'h5A);
		send_beat(OP_START, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h12);
		send_beat(OP_BYTE, 8'h34);
		send_beat(OP_BYTE, 8'h56);
		send_beat(OP_BYTE, 8'h78);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'hAA);
		send_beat(OP_BYTE, 8'h55);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_START, 8'h00);
		send_beat(OP_BYTE, 8'hC3);
		send_beat(OP_BYTE, 8'h3C);
		send_beat(OP_END, 8'hFF);
		send_beat(OP_START, 8'h18);
		send_beat(OP_END, 8'h00);

		// random members, calm stretches now and then, calm throughout the last part
		while (beats_sent < ItemCount) begin
			build_member();
			if (beats_sent >= CalmFrom)
				calm = 1'b1;
			else
				calm = ($urandom_range(0, 7) == 0);
			foreach (member_beats[i]) begin
				if (beats_sent < CalmFrom && $urandom_range(0, 39) == 0)
					send_beat(OP_NONE, 8'($urandom));
				send_beat(opcode_t'(member_beats[i].opcode), member_beats[i].in_byte);
			end
		end
		calm = 1'b1;

		// drain
		@(negedge clk);
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/gzhs_pkg.sv
hw/rtl/gzip_header_skipper_top.sv
test/gzhs_checker.sv
test/tb_top.sv
